/* rtl/core/min_coin_change_solver_defines.svh */
// Assertion macros for the minimum coin change solver.
// Included by the port checker; no other dependencies.
`ifndef MIN_COIN_CHANGE_SOLVER_DEFINES_SVH
`define MIN_COIN_CHANGE_SOLVER_DEFINES_SVH

// same-cycle implication, reset masked
`define MCCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define MCCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mccs_pkg.sv */
// Shared widths, types and constants for the minimum coin change solver.
// No dependencies.
`timescale 1ns / 1ps

package mccs_pkg;

  localparam int AmtW        = 8;
  localparam int CoinW       = 8;
  localparam int CntW        = 8;
  localparam int EntryW      = CntW + 1;
  localparam int NumCoinRegs = 3;
  localparam int CfgIdxW     = 2;
  localparam int StepW       = 2;

  typedef logic [CoinW-1:0]  coin_t;
  typedef logic [EntryW-1:0] entry_t;

  localparam coin_t CoinAReset = 8'd2;
  localparam coin_t CoinBReset = 8'd5;
  localparam coin_t CoinCReset = 8'd7;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCoinA = 2'd0,
    CfgCoinB = 2'd1,
    CfgCoinC = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } tbl_ctl_t;

endpackage

/* rtl/core/mccs_table.sv */
// Best-count table: one write port, one read port, registered read data.
// Depends on mccs_pkg.
`timescale 1ns / 1ps

module mccs_table #(
  parameter int Depth = 256,
  parameter int AddrW = 8
) (
  input  logic                 clk_i,
  input  mccs_pkg::tbl_ctl_t   ctl_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  mccs_pkg::entry_t     wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output mccs_pkg::entry_t     rdata_o
);

  mccs_pkg::entry_t mem_q [Depth];
  mccs_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/min_coin_change_solver.sv */
// Minimum coin change solver, top level: coin registers, fill sequencer, table.
// Depends on mccs_pkg and mccs_table.
//
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------
//  request | start / busy               | target_amount_i
//  result  | done_o (one-cycle strobe)  | coin_count_o, reachable_o
//  config  | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Target 0 or above MAX_AMOUNT: result strobe in the cycle after the transfer.
// Otherwise the sequencer fills the table for amounts 1 to target: at most one table
// lookup per coin on the single read port, then one write per amount.
// busy is low again in the strobe cycle. The table needs no clearing after
// reset. Results cannot be stalled; config is always ready.
`timescale 1ns / 1ps

module min_coin_change_solver #(
  parameter int MAX_AMOUNT = 255,
  parameter int NUM_COINS  = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [mccs_pkg::AmtW-1:0]     target_amount_i,
  output logic                          done_o,
  output logic [mccs_pkg::CntW-1:0]     coin_count_o,
  output logic                          reachable_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mccs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mccs_pkg::CoinW-1:0]    cfg_data_i
);

  localparam int Depth   = MAX_AMOUNT + 1;
  localparam int AddrW   = $clog2(Depth);
  localparam int NumUsed = (NUM_COINS > mccs_pkg::NumCoinRegs) ?
                           mccs_pkg::NumCoinRegs : NUM_COINS;
  localparam int StepW   = mccs_pkg::StepW;
  localparam int AmtW    = mccs_pkg::AmtW;
  localparam int CntW    = mccs_pkg::CntW;

  typedef enum logic {
    StIdle,
    StFill
  } state_e;

  state_e                state_q;
  logic [AmtW-1:0]       amt_q;
  logic [AmtW-1:0]       target_q;
  logic [StepW-1:0]      step_q;
  logic                  found_q;
  logic [CntW:0]         best_q;
  logic                  pend_q;
  logic                  done_q;
  logic [CntW-1:0]       count_q;
  logic                  reach_q;

  mccs_pkg::coin_t       coin_q [mccs_pkg::NumCoinRegs];

  mccs_pkg::coin_t       coin_sel;
  logic                  accept;
  logic                  in_range;
  logic                  issue;
  logic                  last_step;
  logic                  take;
  logic                  found_n;
  logic [CntW:0]         cand;
  logic [CntW:0]         best_n;
  mccs_pkg::tbl_ctl_t    tbl_ctl;
  logic [AddrW-1:0]      waddr;
  logic [AddrW-1:0]      raddr;
  mccs_pkg::entry_t      wdata;
  mccs_pkg::entry_t      rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coin_q[0] <= mccs_pkg::CoinAReset;
      coin_q[1] <= mccs_pkg::CoinBReset;
      coin_q[2] <= mccs_pkg::CoinCReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        mccs_pkg::CfgCoinA: coin_q[0] <= cfg_data_i;
        mccs_pkg::CfgCoinB: coin_q[1] <= cfg_data_i;
        mccs_pkg::CfgCoinC: coin_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept    = start && !busy;
  assign in_range  = 32'(target_amount_i) <= MAX_AMOUNT;
  assign last_step = step_q == StepW'(NumUsed);

  always_comb begin
    coin_sel = '0;
    if (step_q < StepW'(NumUsed)) begin
      coin_sel = coin_q[step_q];
    end
  end

  assign issue = (state_q == StFill) && !last_step && (coin_sel != '0) &&
                 (coin_sel <= amt_q);
  assign raddr = AddrW'(amt_q - coin_sel);

  // fold in the lookup issued last cycle
  assign cand    = {1'b0, rdata[CntW-1:0]} + {{CntW{1'b0}}, 1'b1};
  assign take    = pend_q && rdata[CntW] && (!found_q || (cand < best_q));
  assign found_n = found_q || take;
  assign best_n  = take ? cand : best_q;

  always_comb begin
    tbl_ctl.rd_en = issue;
    tbl_ctl.wr_en = 1'b0;
    waddr         = '0;
    wdata         = {1'b1, {CntW{1'b0}}};
    if (state_q == StIdle) begin
      tbl_ctl.wr_en = accept && in_range;
    end else begin
      tbl_ctl.wr_en = last_step;
      waddr         = AddrW'(amt_q);
      wdata         = found_n ? {1'b1, best_n[CntW-1:0]} : '0;
    end
  end

  mccs_table #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_table (
    .clk_i   (clk_i),
    .ctl_i   (tbl_ctl),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      amt_q    <= '0;
      target_q <= '0;
      step_q   <= '0;
      found_q  <= 1'b0;
      best_q   <= '0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
      count_q  <= '0;
      reach_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            target_q <= target_amount_i;
            amt_q    <= {{(AmtW-1){1'b0}}, 1'b1};
            step_q   <= '0;
            found_q  <= 1'b0;
            pend_q   <= 1'b0;
            if (!in_range) begin
              done_q  <= 1'b1;
              count_q <= '0;
              reach_q <= 1'b0;
            end else if (target_amount_i == '0) begin
              done_q  <= 1'b1;
              count_q <= '0;
              reach_q <= 1'b1;
            end else begin
              state_q <= StFill;
            end
          end
        end
        StFill: begin
          pend_q <= issue;
          if (last_step) begin
            found_q <= 1'b0;
            step_q  <= '0;
            if (amt_q == target_q) begin
              done_q  <= 1'b1;
              count_q <= found_n ? best_n[CntW-1:0] : '0;
              reach_q <= found_n;
              state_q <= StIdle;
            end else begin
              amt_q <= amt_q + {{(AmtW-1){1'b0}}, 1'b1};
            end
          end else begin
            step_q  <= step_q + {{(StepW-1){1'b0}}, 1'b1};
            found_q <= found_n;
            best_q  <= best_n;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy         = state_q != StIdle;
  assign done_o       = done_q;
  assign coin_count_o = count_q;
  assign reachable_o  = reach_q;

endmodule

/* rtl/core/mccs_checker.sv */
// Port-level checker for the minimum coin change solver, bound to the top level.
// Depends on min_coin_change_solver_defines.svh and mccs_pkg.
`timescale 1ns / 1ps
`include "min_coin_change_solver_defines.svh"

module mccs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       done_o,
  input logic [mccs_pkg::CntW-1:0]  coin_count_o,
  input logic                       reachable_o
);

  `MCCS_ASSERT_NOW(a_done_not_busy, clk_i, rst_ni, done_o, !busy, "result while busy")
  `MCCS_ASSERT_NEXT(a_busy_ends_in_result, clk_i, rst_ni, busy, busy || done_o, "busy dropped without result")
  `MCCS_ASSERT_NOW(a_busy_from_start, clk_i, rst_ni, $rose(busy), $past(start), "busy rose without a start transfer")
  `MCCS_ASSERT_NOW(a_unreach_zero, clk_i, rst_ni, done_o && !reachable_o, coin_count_o == '0, "unreachable with nonzero count")

endmodule

bind min_coin_change_solver mccs_checker u_mccs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .coin_count_o (coin_count_o),
  .reachable_o  (reachable_o)
);

/* tb/sv/testbench.sv */
// Self-checking testbench for min_coin_change_solver: random and directed targets
// under several coin sets, results checked against an in-bench coin table.
// Depends on mccs_pkg and the solver RTL.
`timescale 1ns / 1ps

module testbench;

  localparam logic [mccs_pkg::CfgIdxW-1:0] CfgUnmapped = 2'd3;
  localparam int SettleCycles = 1030;

  typedef struct {
    bit                           is_cfg;
    logic [mccs_pkg::CfgIdxW-1:0] idx;
    mccs_pkg::coin_t              data;
    logic [mccs_pkg::AmtW-1:0]    amount;
  } pending_op_t;

  typedef struct {
    logic [mccs_pkg::AmtW-1:0] amount;
    logic [mccs_pkg::CntW-1:0] count;
    logic                      reach;
  } change_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [mccs_pkg::AmtW-1:0]    target_amount_i = '0;
  logic                         done_o;
  logic [mccs_pkg::CntW-1:0]    coin_count_o;
  logic                         reachable_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [mccs_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [mccs_pkg::CoinW-1:0]   cfg_data_i = '0;

  pending_op_t     pending_ops[$];
  change_t         awaited_change[$];
  mccs_pkg::coin_t denom[mccs_pkg::NumCoinRegs] =
    '{mccs_pkg::CoinAReset, mccs_pkg::CoinBReset, mccs_pkg::CoinCReset};
  bit              start_taken = 1'b0;
  bit              cfg_taken = 1'b0;
  int              items_driven = 0;
  int              mismatch_count = 0;

  min_coin_change_solver dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .target_amount_i (target_amount_i),
    .done_o          (done_o),
    .coin_count_o    (coin_count_o),
    .reachable_o     (reachable_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // bottom-up table over the current denominations; -1 marks unreachable
  function automatic change_t fewest_coins(input logic [mccs_pkg::AmtW-1:0] amount);
    int      fewest [0:255];
    int      amt;
    int      c;
    int      cand;
    change_t r;
    fewest[0] = 0;
    for (amt = 1; amt <= amount; amt++) begin
      fewest[amt] = -1;
      for (int k = 0; k < mccs_pkg::NumCoinRegs; k++) begin
        c = denom[k];
        if (c != 0 && c <= amt && fewest[amt-c] >= 0) begin
          cand = fewest[amt-c] + 1;
          if (fewest[amt] < 0 || cand < fewest[amt]) fewest[amt] = cand;
        end
      end
    end
    r.amount = amount;
    if (fewest[amount] >= 0) begin
      r.count = fewest[amount][mccs_pkg::CntW-1:0];
      r.reach = 1'b1;
    end else begin
      r.count = '0;
      r.reach = 1'b0;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int exp_v, input int act_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t mismatch: %s expected %0d got %0d", $realtime, what, exp_v, act_v);
  endtask

  task automatic queue_item(input logic [mccs_pkg::AmtW-1:0] amount);
    pending_op_t op;
    op.is_cfg = 1'b0;
    op.idx = '0;
    op.data = '0;
    op.amount = amount;
    pending_ops.push_back(op);
  endtask

  task automatic queue_coin_write(input logic [mccs_pkg::CfgIdxW-1:0] idx,
                                  input mccs_pkg::coin_t data);
    pending_op_t op;
    op.is_cfg = 1'b1;
    op.idx = idx;
    op.data = data;
    op.amount = '0;
    pending_ops.push_back(op);
  endtask

  task automatic queue_coin_set(input mccs_pkg::coin_t a, input mccs_pkg::coin_t b,
                                input mccs_pkg::coin_t c);
    queue_coin_write(mccs_pkg::CfgCoinA, a);
    queue_coin_write(mccs_pkg::CfgCoinB, b);
    queue_coin_write(mccs_pkg::CfgCoinC, c);
  endtask

  // mostly short fills, a tenth across the full range
  function automatic logic [mccs_pkg::AmtW-1:0] pick_target();
    if ($urandom_range(99) < 10) return mccs_pkg::AmtW'($urandom_range(255));
    return mccs_pkg::AmtW'($urandom_range(40));
  endfunction

  function automatic mccs_pkg::coin_t pick_coin();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 70) return mccs_pkg::CoinW'($urandom_range(20, 1));
    return mccs_pkg::CoinW'($urandom_range(255, 21));
  endfunction

  // driver: one op at a time from the head of the queue
  always @(negedge clk_i) begin : driver
    pending_op_t op;
    logic        start_nxt;
    logic        cfg_nxt;
    bit          quiet;
    start_nxt = start;
    cfg_nxt = cfg_valid_i;
    quiet = items_driven >= 300 && items_driven < 420;
    if (start_taken) begin
      start_nxt = 1'b0;
      void'(pending_ops.pop_front());
      items_driven = items_driven + 1;
    end
    if (cfg_taken) begin
      cfg_nxt = 1'b0;
      void'(pending_ops.pop_front());
    end
    if (rst_ni && !start_nxt && !cfg_nxt && pending_ops.size() != 0 &&
        (quiet || $urandom_range(99) >= 34)) begin
      op = pending_ops[0];
      if (op.is_cfg) begin
        if (awaited_change.size() == 0 && !busy) begin
          cfg_nxt = 1'b1;
          cfg_index_i <= op.idx;
          cfg_data_i <= op.data;
        end
      end else begin
        start_nxt = 1'b1;
        target_amount_i <= op.amount;
      end
    end
    start <= start_nxt;
    cfg_valid_i <= cfg_nxt;
  end

  // monitor: transfers at the rising edge, checking and prediction
  always @(posedge clk_i) begin : monitor
    change_t want;
    if (!rst_ni) begin
      start_taken = 1'b0;
      cfg_taken = 1'b0;
    end else begin
      start_taken = start && !busy;
      cfg_taken = cfg_valid_i && cfg_ready_o;
      if (done_o) begin
        if (awaited_change.size() == 0) begin
          flag_mismatch("result with nothing outstanding, count", -1, coin_count_o);
        end else begin
          want = awaited_change.pop_front();
          if (coin_count_o !== want.count)
            flag_mismatch($sformatf("coin_count for target %0d", want.amount),
                          want.count, coin_count_o);
          if (reachable_o !== want.reach)
            flag_mismatch($sformatf("reachable for target %0d", want.amount),
                          want.reach, reachable_o);
        end
      end
      if (cfg_taken && cfg_index_i < mccs_pkg::NumCoinRegs)
        denom[cfg_index_i] = cfg_data_i;
      if (start_taken) awaited_change.push_back(fewest_coins(target_amount_i));
    end
  end

  initial begin : stimulus
    logic [mccs_pkg::AmtW-1:0] directed [] =
      '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 11, 13, 127, 128, 254, 255};
    foreach (directed[i]) queue_item(directed[i]);
    queue_coin_set(8'd1, 8'd255, 8'd128);
    queue_item(8'd255);
    queue_item(8'd254);
    queue_item(8'd129);
    queue_coin_set(8'd0, 8'd0, 8'd0);
    queue_coin_write(CfgUnmapped, 8'd1);
    queue_item(8'd0);
    queue_item(8'd3);
    queue_item(8'd255);
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: queue_coin_set(8'd255, 8'd255, 8'd255);
        1: queue_coin_set(8'd3, 8'd0, 8'd10);
        2: queue_coin_set(8'd1, 8'd1, 8'd1);
        3: queue_coin_set(8'd4, 8'd6, 8'd9);
        default: queue_coin_set(pick_coin(), pick_coin(), pick_coin());
      endcase
      if ($urandom_range(2) == 0) queue_coin_write(CfgUnmapped, pick_coin());
      for (int n = 0; n < 73; n++) queue_item(pick_target());
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || awaited_change.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
